>>> src/ble_advert_filter_table_unit_assert.svh
// ----------------------------------------------------------------------------
// BLE advertising filter: assertion macros
// Shared concurrent assertion forms; clk and rst_n come from the using module.
// ----------------------------------------------------------------------------
`ifndef BLE_ADVERT_FILTER_TABLE_UNIT_ASSERT_SVH
`define BLE_ADVERT_FILTER_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define BLEAFT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BLEAFT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bleaft_pkg.sv
// ----------------------------------------------------------------------------
// BLE advertising filter package
// Shared widths, codes and the token that walks the device table chain.
// ----------------------------------------------------------------------------
package bleaft_pkg;

  localparam int ADDR_W     = 48;
  localparam int RSSI_W     = 8;
  localparam int SLOT_W     = 4;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int UUID_W     = 16;
  localparam int PLEN_W     = 4;
  localparam int NAME_MAX   = 31;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SERVICE_UUID  = 2'd0;
  localparam cfg_idx_t CFG_COMPANY_ID    = 2'd1;
  localparam cfg_idx_t CFG_NAME_PREFIX   = 2'd2;
  localparam cfg_idx_t CFG_PREFIX_LENGTH = 2'd3;

  localparam logic [UUID_W-1:0] SERVICE_UUID_RST = 16'hFDD0;
  localparam logic [UUID_W-1:0] COMPANY_ID_RST   = 16'hFFFF;

  localparam logic [7:0] AD_TYPE_NAME   = 8'h09;
  localparam logic [7:0] AD_TYPE_UUID16 = 8'h03;
  localparam logic [7:0] AD_TYPE_MANUF  = 8'hFF;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_NAME  = 2'd1,
    KIND_UUID  = 2'd2,
    KIND_MANUF = 2'd3
  } field_kind_t;

  typedef enum logic [3:0] {
    PH_LEN  = 4'b0001,
    PH_TYPE = 4'b0010,
    PH_BODY = 4'b0100,
    PH_END  = 4'b1000
  } parse_phase_t;

  typedef enum logic [1:0] {
    TOK_NONE   = 2'd0,
    TOK_CLEAR  = 2'd1,
    TOK_LOOKUP = 2'd2,
    TOK_PASS   = 2'd3
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t                 kind;
    logic [ADDR_W-1:0]         addr;
    logic signed [RSSI_W-1:0]  rssi;
    logic                      done;
    logic                      added;
    logic [SLOT_W-1:0]         slot;
  } tok_t;

endpackage

>>> src/bleaft_if.sv
// ----------------------------------------------------------------------------
// BLE advertising filter channel interfaces
// Valid/ready channels for payload bytes in and classification results out.
// ----------------------------------------------------------------------------
interface bleaft_in_if;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [7:0]        data_byte;
  logic              last_byte;
  logic [47:0]       device_address;
  logic signed [7:0] signal_strength;

  modport source (output valid, cmd, data_byte, last_byte, device_address, signal_strength,
                  input ready);
  modport sink   (input valid, cmd, data_byte, last_byte, device_address, signal_strength,
                  output ready);
endinterface

interface bleaft_out_if;
  logic              valid;
  logic              ready;
  logic              is_match;
  logic [47:0]       match_address;
  logic signed [7:0] match_strength;
  logic [3:0]        slot;
  logic              newly_added;
  logic              table_full;

  modport source (output valid, is_match, match_address, match_strength, slot, newly_added,
                  table_full, input ready);
  modport sink   (input valid, is_match, match_address, match_strength, slot, newly_added,
                  table_full, output ready);
endinterface

>>> src/bleaft_parser.sv
// ----------------------------------------------------------------------------
// BLE advertising filter: AD structure parser
// Walks length-type-value fields byte by byte and issues one token per
// advertisement (or per table clear) into the device table chain.
// ----------------------------------------------------------------------------
`include "ble_advert_filter_table_unit_assert.svh"

module bleaft_parser import bleaft_pkg::*; #(
  parameter int PREFIX_BYTES = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      advance,
  input  logic                      accept,
  input  logic                      cmd,
  input  logic [7:0]                data_byte,
  input  logic                      last_byte,
  input  logic [ADDR_W-1:0]         device_address,
  input  logic signed [RSSI_W-1:0]  signal_strength,
  input  logic [UUID_W-1:0]         service_uuid,
  input  logic [UUID_W-1:0]         company_id,
  input  logic [8*PREFIX_BYTES-1:0] name_prefix,
  input  logic [PLEN_W-1:0]         prefix_length,
  output tok_t                      tok_o
);

  localparam int          PIDX_W     = (PREFIX_BYTES > 1) ? $clog2(PREFIX_BYTES) : 1;
  localparam logic [7:0]  NAME_MAX_B = 8'(NAME_MAX);
  localparam logic [PLEN_W-1:0] PB_CAP = PLEN_W'(PREFIX_BYTES);

  parse_phase_t phase_r, phase_nxt;
  logic [7:0]   left_r, left_nxt;
  field_kind_t  kind_r, kind_nxt;
  logic [7:0]   bif_r, bif_nxt;
  logic         cok_r, cok_nxt;
  logic         nim_r, nim_nxt;
  logic [7:0]   low_r, low_nxt;
  logic         found_r, found_nxt;
  tok_t         tok_r, tok_nxt;

  logic [PLEN_W-1:0] plen;
  logic [PIDX_W-1:0] pidx;
  logic [7:0]        want;
  logic              in_prefix;

  assign plen      = (prefix_length > PB_CAP) ? PB_CAP : prefix_length;
  assign pidx      = bif_r[PIDX_W-1:0];
  assign want      = name_prefix[{pidx, 3'b000} +: 8];
  assign in_prefix = bif_r < {4'd0, plen};

  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    kind_nxt  = kind_r;
    bif_nxt   = bif_r;
    cok_nxt   = cok_r;
    nim_nxt   = nim_r;
    low_nxt   = low_r;
    found_nxt = found_r;
    tok_nxt   = '0;
    if (accept) begin
      if (cmd) begin
        tok_nxt.kind = TOK_CLEAR;
      end else begin
        unique case (phase_r)
          PH_LEN: begin
            if (data_byte == 8'd0) begin
              phase_nxt = PH_END;
            end else begin
              left_nxt  = data_byte;
              phase_nxt = PH_TYPE;
            end
          end
          PH_TYPE: begin
            case (data_byte)
              AD_TYPE_NAME:   kind_nxt = KIND_NAME;
              AD_TYPE_UUID16: kind_nxt = KIND_UUID;
              AD_TYPE_MANUF:  kind_nxt = KIND_MANUF;
              default:        kind_nxt = KIND_OTHER;
            endcase
            bif_nxt   = 8'd0;
            left_nxt  = left_r - 8'd1;
            phase_nxt = (left_r == 8'd1) ? PH_LEN : PH_BODY;
          end
          PH_BODY: begin
            case (kind_r)
              KIND_NAME: begin
                // a name with any data byte restarts the comparison
                if (bif_r == 8'd0) begin
                  cok_nxt = 1'b1;
                  nim_nxt = 1'b0;
                end
                if (bif_r < NAME_MAX_B) begin
                  if (data_byte == 8'd0) begin
                    bif_nxt = NAME_MAX_B;
                  end else begin
                    if (in_prefix && (want != data_byte)) cok_nxt = 1'b0;
                    nim_nxt = cok_nxt && ((bif_r + 8'd1) >= {4'd0, plen});
                    bif_nxt = bif_r + 8'd1;
                  end
                end
              end
              KIND_UUID: begin
                if (!bif_r[0]) low_nxt = data_byte;
                else if ({data_byte, low_r} == service_uuid) found_nxt = 1'b1;
                if (bif_r != 8'hFF) bif_nxt = bif_r + 8'd1;
              end
              KIND_MANUF: begin
                if (bif_r == 8'd0) low_nxt = data_byte;
                else if ((bif_r == 8'd1) && ({data_byte, low_r} == company_id))
                  found_nxt = 1'b1;
                if (bif_r != 8'hFF) bif_nxt = bif_r + 8'd1;
              end
              default: begin
                if (bif_r != 8'hFF) bif_nxt = bif_r + 8'd1;
              end
            endcase
            left_nxt = left_r - 8'd1;
            if (left_r == 8'd1) phase_nxt = PH_LEN;
          end
          PH_END: ;
          default: ;
        endcase
        if (last_byte) begin
          tok_nxt.kind = (nim_nxt || found_nxt) ? TOK_LOOKUP : TOK_PASS;
          tok_nxt.addr = device_address;
          tok_nxt.rssi = signal_strength;
          phase_nxt    = PH_LEN;
          left_nxt     = 8'd0;
          kind_nxt     = KIND_OTHER;
          bif_nxt      = 8'd0;
          cok_nxt      = 1'b0;
          nim_nxt      = 1'b0;
          low_nxt      = 8'd0;
          found_nxt    = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEN;
      left_r  <= 8'd0;
      kind_r  <= KIND_OTHER;
      bif_r   <= 8'd0;
      cok_r   <= 1'b0;
      nim_r   <= 1'b0;
      low_r   <= 8'd0;
      found_r <= 1'b0;
      tok_r   <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      kind_r  <= kind_nxt;
      bif_r   <= bif_nxt;
      cok_r   <= cok_nxt;
      nim_r   <= nim_nxt;
      low_r   <= low_nxt;
      found_r <= found_nxt;
      tok_r   <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

  `BLEAFT_ASSERT_NEXT(a_restart_after_last, accept && !cmd && last_byte,
    phase_r == PH_LEN && !found_r && !nim_r && tok_r.kind != TOK_NONE, "parser not reset after last byte")

endmodule

>>> src/bleaft_cell.sv
// ----------------------------------------------------------------------------
// BLE advertising filter: device table cell
// Holds one table entry; refreshes it, claims it, or clears it as tokens
// pass through, then hands the token to the next cell.
// ----------------------------------------------------------------------------
`include "ble_advert_filter_table_unit_assert.svh"

module bleaft_cell import bleaft_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic advance,
  input  tok_t tok_i,
  output tok_t tok_o
);

  localparam logic [SLOT_W-1:0] SLOT_NUM = SLOT_W'(IDX);

  logic                     valid_r, valid_nxt;
  logic [ADDR_W-1:0]        addr_r, addr_nxt;
  logic signed [RSSI_W-1:0] strength_r, strength_nxt;
  tok_t                     tok_r, tok_nxt;
  logic                     hit;

  assign hit = valid_r && (addr_r == tok_i.addr);

  // valid entries always form a prefix of the chain, so the first empty cell
  // reached by an unresolved lookup is the first free slot
  always_comb begin
    valid_nxt    = valid_r;
    addr_nxt     = addr_r;
    strength_nxt = strength_r;
    tok_nxt      = tok_i;
    case (tok_i.kind)
      TOK_CLEAR: valid_nxt = 1'b0;
      TOK_LOOKUP: begin
        if (!tok_i.done) begin
          if (hit) begin
            strength_nxt = tok_i.rssi;
            tok_nxt.done = 1'b1;
            tok_nxt.slot = SLOT_NUM;
          end else if (!valid_r) begin
            valid_nxt     = 1'b1;
            addr_nxt      = tok_i.addr;
            strength_nxt  = tok_i.rssi;
            tok_nxt.done  = 1'b1;
            tok_nxt.added = 1'b1;
            tok_nxt.slot  = SLOT_NUM;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else if (advance) begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      addr_r     <= addr_nxt;
      strength_r <= strength_nxt;
    end
  end

  assign tok_o = tok_r;

  `BLEAFT_ASSERT_NEXT(a_claim_free_slot,
    advance && tok_i.kind == TOK_LOOKUP && !tok_i.done && !valid_r,
    valid_r && tok_r.added && addr_r == $past(tok_i.addr), "free slot not claimed")

endmodule

>>> src/ble_advert_filter_table_unit.sv
// ----------------------------------------------------------------------------
// BLE advertising filter with device table
// Parses advertising payload bytes and keeps a table of matching devices.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while the chain is not held. Each
// advertisement's result passes from its last byte through the parser's
// token register, the register in every table cell of the chain that holds
// the device table, and the output register. Table clears travel the same
// chain, so results always reflect every clear and insert taken before them.
// When a result waits unaccepted in the output register and the next result
// has reached the end of the chain, the whole chain holds and input ready
// drops in the same cycle.
`include "ble_advert_filter_table_unit_assert.svh"

module ble_advert_filter_table_unit import bleaft_pkg::*; #(
  parameter int DEVICE_SLOTS = 16,
  parameter int PREFIX_BYTES = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bleaft_in_if.sink             in_chan,
  bleaft_out_if.source          out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [UUID_W-1:0]         service_uuid_r;
  logic [UUID_W-1:0]         company_id_r;
  logic [8*PREFIX_BYTES-1:0] name_prefix_r;
  logic [PLEN_W-1:0]         prefix_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      service_uuid_r  <= SERVICE_UUID_RST;
      company_id_r    <= COMPANY_ID_RST;
      name_prefix_r   <= '0;
      prefix_length_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SERVICE_UUID:  service_uuid_r  <= cfg_data[UUID_W-1:0];
        CFG_COMPANY_ID:    company_id_r    <= cfg_data[UUID_W-1:0];
        CFG_NAME_PREFIX:   name_prefix_r   <= cfg_data[8*PREFIX_BYTES-1:0];
        CFG_PREFIX_LENGTH: prefix_length_r <= cfg_data[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  tok_t chain [DEVICE_SLOTS+1];
  tok_t tail;
  logic tail_res;
  logic advance;
  logic accept;

  logic                     out_valid_r;
  logic                     out_is_match_r;
  logic [ADDR_W-1:0]        out_addr_r;
  logic signed [RSSI_W-1:0] out_strength_r;
  logic [SLOT_W-1:0]        out_slot_r;
  logic                     out_added_r;
  logic                     out_full_r;

  assign tail     = chain[DEVICE_SLOTS];
  assign tail_res = (tail.kind == TOK_LOOKUP) || (tail.kind == TOK_PASS);
  assign advance  = !(out_valid_r && !out_chan.ready && tail_res);
  assign accept   = in_chan.valid && advance;
  assign in_chan.ready = advance;

  bleaft_parser #(
    .PREFIX_BYTES (PREFIX_BYTES)
  ) u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .advance         (advance),
    .accept          (accept),
    .cmd             (in_chan.cmd),
    .data_byte       (in_chan.data_byte),
    .last_byte       (in_chan.last_byte),
    .device_address  (in_chan.device_address),
    .signal_strength (in_chan.signal_strength),
    .service_uuid    (service_uuid_r),
    .company_id      (company_id_r),
    .name_prefix     (name_prefix_r),
    .prefix_length   (prefix_length_r),
    .tok_o           (chain[0])
  );

  for (genvar i = 0; i < DEVICE_SLOTS; i++) begin : g_cell
    bleaft_cell #(
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .tok_i   (chain[i]),
      .tok_o   (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && tail_res) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tail_res) begin
      out_is_match_r <= (tail.kind == TOK_LOOKUP);
      out_addr_r     <= tail.addr;
      out_strength_r <= tail.rssi;
      out_slot_r     <= tail.slot;
      out_added_r    <= tail.added;
      out_full_r     <= (tail.kind == TOK_LOOKUP) && !tail.done;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.is_match       = out_is_match_r;
  assign out_chan.match_address  = out_addr_r;
  assign out_chan.match_strength = out_strength_r;
  assign out_chan.slot           = out_slot_r;
  assign out_chan.newly_added    = out_added_r;
  assign out_chan.table_full     = out_full_r;

  `BLEAFT_ASSERT_IMPL(a_added_or_full, out_valid_r, !(out_added_r && out_full_r),
    "result both added and dropped")
  `BLEAFT_ASSERT_IMPL(a_nomatch_clean, out_valid_r && !out_is_match_r,
    out_slot_r == '0 && !out_added_r && !out_full_r, "non-match carries table status")

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BLE advertising filter testbench
// Streams advertising payloads through the filter under several register
// settings, predicts the classification results (directed rows carry hand-written
// ones) and the device table contents locally, and checks each result field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import bleaft_pkg::*;

  localparam int TB_SLOTS        = 16;
  localparam int TB_PREFIX       = 8;
  localparam int ADDR_POOL       = 20;
  localparam int SETTLE_CYCLES   = 40;   // table chain is TB_SLOTS + 2 deep
  localparam int PHASE_ITEMS     = 280;
  localparam int NUM_PHASES      = 5;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int MAX_REPORTS     = 10;

  localparam logic [47:0] ADDR_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] ADDR_A   = 48'h0123_4567_89AB;
  localparam logic [47:0] ADDR_B   = 48'hA5A5_5A5A_C3C3;

  typedef struct packed {
    logic              is_match;
    logic [47:0]       addr;
    logic signed [7:0] strength;
    logic [3:0]        slot;
    logic              added;
    logic              full;
  } adv_result_t;

  typedef struct {
    logic        cmd;
    logic [7:0]  data;
    logic        last;
    logic [47:0] addr;
    logic [7:0]  rssi;
    bit          has_typed;
    adv_result_t typed;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bleaft_in_if  in_ch ();
  bleaft_out_if out_ch ();

  ble_advert_filter_table_unit #(
    .DEVICE_SLOTS(TB_SLOTS),
    .PREFIX_BYTES(TB_PREFIX)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // ---------------- predictor state ----------------
  logic [15:0]  want_uuid;
  logic [15:0]  want_company;
  logic [63:0]  want_prefix;
  logic [3:0]   want_plen;

  parse_phase_t adv_phase;
  logic [7:0]   field_left;
  field_kind_t  adv_kind;
  logic [7:0]   field_pos;
  bit           name_ok;
  bit           name_hit;
  logic [7:0]   held_low;
  bit           id_hit;
  logic [47:0]  dev_addr [TB_SLOTS];
  logic [7:0]   dev_rssi [TB_SLOTS];
  bit           dev_used [TB_SLOTS];

  adv_result_t  expected_q[$];
  stim_row_t    directed_rows[$];
  stim_row_t    cur_item;
  logic [7:0]   adv_bytes[$];
  logic [47:0]  addr_pool [ADDR_POOL];

  int  err_count;
  int  stall_cycles;
  int  items_sent;
  bit  no_idle;

  function automatic int eff_plen();
    return (want_plen > TB_PREFIX) ? TB_PREFIX : int'(want_plen);
  endfunction

  function void parser_restart();
    adv_phase  = PH_LEN;
    field_left = '0;
    adv_kind   = KIND_OTHER;
    field_pos  = '0;
    name_ok    = 0;
    name_hit   = 0;
    held_low   = '0;
    id_hit     = 0;
  endfunction

  function void name_char(logic [7:0] b);
    int plen;
    int pos;
    plen = eff_plen();
    if (field_pos == 0) begin
      name_ok  = 1;
      name_hit = 0;
    end
    if (field_pos >= NAME_MAX) return;
    if (b == 8'h00) begin
      field_pos = 8'(NAME_MAX);   // zero byte ends the name
      return;
    end
    pos = int'(field_pos);
    if (pos < plen && want_prefix[8*pos +: 8] != b) name_ok = 0;
    name_hit  = name_ok && (pos + 1 >= plen);
    field_pos = field_pos + 8'd1;
  endfunction

  function void body_char(logic [7:0] b);
    if (adv_kind == KIND_NAME) begin
      name_char(b);
      return;
    end
    if (adv_kind == KIND_UUID) begin
      if (field_pos[0] == 1'b0) held_low = b;
      else if ({b, held_low} == want_uuid) id_hit = 1;
    end else if (adv_kind == KIND_MANUF) begin
      if (field_pos == 0) held_low = b;
      else if (field_pos == 1 && {b, held_low} == want_company) id_hit = 1;
    end
    if (field_pos != 8'hFF) field_pos = field_pos + 8'd1;
  endfunction

  function void parse_char(logic [7:0] b);
    case (adv_phase)
      PH_LEN: begin
        if (b == 8'h00) begin
          adv_phase = PH_END;
        end else begin
          field_left = b;
          adv_phase  = PH_TYPE;
        end
      end
      PH_TYPE: begin
        if (b == AD_TYPE_NAME) adv_kind = KIND_NAME;
        else if (b == AD_TYPE_UUID16) adv_kind = KIND_UUID;
        else if (b == AD_TYPE_MANUF) adv_kind = KIND_MANUF;
        else adv_kind = KIND_OTHER;
        field_pos  = '0;
        field_left = field_left - 8'd1;
        adv_phase  = (field_left == 0) ? PH_LEN : PH_BODY;
      end
      PH_BODY: begin
        body_char(b);
        field_left = field_left - 8'd1;
        if (field_left == 0) adv_phase = PH_LEN;
      end
      default: ;
    endcase
  endfunction

  // returns 1 when the transaction yields a classification result
  function bit classify_item(logic cmd, logic [7:0] b, logic last, logic [47:0] addr,
                             logic [7:0] rssi, output adv_result_t r);
    bit hit;
    bit done;
    r = '0;
    if (cmd) begin
      foreach (dev_used[i]) dev_used[i] = 0;
      return 0;
    end
    parse_char(b);
    if (!last) return 0;
    hit  = name_hit || id_hit;
    done = 0;
    r.is_match = hit;
    r.addr     = addr;
    r.strength = rssi;
    if (hit) begin
      for (int i = 0; i < TB_SLOTS && !done; i++) begin
        if (dev_used[i] && dev_addr[i] == addr) begin
          dev_rssi[i] = rssi;
          r.slot = i[3:0];
          done = 1;
        end
      end
      for (int i = 0; i < TB_SLOTS && !done; i++) begin
        if (!dev_used[i]) begin
          dev_used[i] = 1;
          dev_addr[i] = addr;
          dev_rssi[i] = rssi;
          r.slot  = i[3:0];
          r.added = 1;
          done = 1;
        end
      end
      if (!done) r.full = 1;
    end
    parser_restart();
    return 1;
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[47:0];
  endfunction

  function automatic stim_row_t row(logic cmd, logic [7:0] b, logic last, logic [47:0] addr,
                                    logic [7:0] rssi);
    stim_row_t r;
    r.cmd = cmd;
    r.data = b;
    r.last = last;
    r.addr = addr;
    r.rssi = rssi;
    r.has_typed = 0;
    r.typed = '0;
    return r;
  endfunction

  // last byte of an advertisement with its result written out by hand
  function automatic stim_row_t row_t(logic [7:0] b, logic [47:0] addr, logic [7:0] rssi,
                                      logic m, logic [3:0] slot, logic added);
    stim_row_t r;
    r = row(1'b0, b, 1'b1, addr, rssi);
    r.has_typed = 1;
    r.typed = {m, addr, rssi, slot, added, 1'b0};
    return r;
  endfunction

  function void add_row(stim_row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  function void add_byte(logic [7:0] b);
    adv_bytes.insert(adv_bytes.size(), b);
  endfunction

  function void note_error(string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // ---------------- random advertisement builder ----------------
  function void build_advert();
    int nf, len, n, odd, extra;
    bit follow;
    logic [7:0] c;
    logic [15:0] id;
    adv_bytes.delete();
    if ($urandom_range(0, 9) < 2) begin
      n = $urandom_range(1, 12);
      repeat (n) add_byte(8'($urandom_range(0, 255)));
      return;
    end
    nf = $urandom_range(1, 3);
    repeat (nf) begin
      case ($urandom_range(0, 3))
        0: begin
          if ($urandom_range(0, 19) == 0) len = 0;
          else if ($urandom_range(0, 9) < 7) len = $urandom_range(1, 12);
          else len = $urandom_range(25, 40);
          follow = ($urandom_range(0, 3) != 0);
          add_byte(8'(len + 1));
          add_byte(AD_TYPE_NAME);
          for (int i = 0; i < len; i++) begin
            if (follow && i < eff_plen()) c = want_prefix[8*i +: 8];
            else c = 8'($urandom_range(32, 126));
            if ($urandom_range(0, 19) == 0) c = 8'h00;
            if (follow && $urandom_range(0, 29) == 0) c = c ^ 8'h01;
            add_byte(c);
          end
        end
        1: begin
          n   = $urandom_range(0, 4);
          odd = ($urandom_range(0, 3) == 0);
          add_byte(8'(1 + 2 * n + odd));
          add_byte(AD_TYPE_UUID16);
          repeat (n) begin
            id = ($urandom_range(0, 2) == 0) ? want_uuid : 16'($urandom);
            add_byte(id[7:0]);
            add_byte(id[15:8]);
          end
          if (odd) add_byte(8'($urandom_range(0, 255)));
        end
        2: begin
          id = ($urandom_range(0, 1) == 0) ? want_company : 16'($urandom);
          if ($urandom_range(0, 6) == 0) begin
            // lone company-id byte
            add_byte(8'd2);
            add_byte(AD_TYPE_MANUF);
            add_byte(id[7:0]);
          end else begin
            extra = $urandom_range(0, 6);
            add_byte(8'(3 + extra));
            add_byte(AD_TYPE_MANUF);
            add_byte(id[7:0]);
            add_byte(id[15:8]);
            repeat (extra) add_byte(8'($urandom_range(0, 255)));
          end
        end
        default: begin
          len = $urandom_range(0, 8);
          add_byte(8'(len + 1));
          add_byte(8'($urandom_range(0, 255)));
          repeat (len) add_byte(8'($urandom_range(0, 255)));
        end
      endcase
    end
    if ($urandom_range(0, 6) == 0) begin
      add_byte(8'h00);
      n = $urandom_range(0, 4);
      repeat (n) add_byte(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, adv_bytes.size());
      while (adv_bytes.size() > n) void'(adv_bytes.pop_back());
    end
  endfunction

  // ---------------- drivers ----------------
  task automatic send_item(stim_row_t r);
    int n;
    if (!no_idle && $urandom_range(0, 11) == 0) begin
      n = $urandom_range(1, 17);
      repeat (n) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_ch.valid           <= 1'b1;
    in_ch.cmd             <= r.cmd;
    in_ch.data_byte       <= r.data;
    in_ch.last_byte       <= r.last;
    in_ch.device_address  <= r.addr;
    in_ch.signal_strength <= r.rssi;
    cur_item = r;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    items_sent++;
  endtask

  task automatic send_advert();
    logic [47:0] a;
    int sz;
    build_advert();
    a = ($urandom_range(0, 9) < 7) ? addr_pool[$urandom_range(0, ADDR_POOL - 1)] : rand48();
    sz = adv_bytes.size();
    for (int i = 0; i < sz; i++) begin
      if ($urandom_range(0, 99) == 0)
        send_item(row(1'b1, 8'($urandom), 1'($urandom), rand48(), 8'($urandom)));
      if (i == sz - 1) send_item(row(1'b0, adv_bytes[i], 1'b1, a, 8'($urandom)));
      else send_item(row(1'b0, adv_bytes[i], 1'b0, rand48(), 8'($urandom)));
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [63:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    case (idx)
      CFG_SERVICE_UUID:  want_uuid    = v[15:0];
      CFG_COMPANY_ID:    want_company = v[15:0];
      CFG_NAME_PREFIX:   want_prefix  = v;
      CFG_PREFIX_LENGTH: want_plen    = v[3:0];
      default: ;
    endcase
  endtask

  // ---------------- clock, receiver, monitor, watchdog ----------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    int n;
    out_ch.ready = 1'b0;
    forever begin
      if (!no_idle && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 17);
        repeat (n) begin
          @(negedge clk);
          out_ch.ready <= 1'b0;
        end
      end else begin
        n = $urandom_range(1, 30);
        repeat (n) begin
          @(negedge clk);
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    adv_result_t pred_r, exp_r, got_r;
    bit moved;
    moved = 0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        moved = 1;
        if (classify_item(in_ch.cmd, in_ch.data_byte, in_ch.last_byte, in_ch.device_address,
                          in_ch.signal_strength, pred_r))
          expected_q.insert(expected_q.size(), cur_item.has_typed ? cur_item.typed : pred_r);
      end
      if (out_ch.valid && out_ch.ready) begin
        moved = 1;
        got_r = {out_ch.is_match, out_ch.match_address, out_ch.match_strength, out_ch.slot,
                 out_ch.newly_added, out_ch.table_full};
        if (expected_q.size() == 0) begin
          note_error($sformatf("unexpected result: match=%0b addr=%h str=%0d slot=%0d",
                               got_r.is_match, got_r.addr, $signed(got_r.strength),
                               got_r.slot));
        end else begin
          exp_r = expected_q.pop_front();
          if (got_r !== exp_r)
            note_error($sformatf(
              "mismatch exp m=%0b a=%h s=%0d sl=%0d n=%0b f=%0b got m=%0b a=%h s=%0d sl=%0d n=%0b f=%0b",
              exp_r.is_match, exp_r.addr, $signed(exp_r.strength), exp_r.slot, exp_r.added,
              exp_r.full, got_r.is_match, got_r.addr, $signed(got_r.strength), got_r.slot,
              got_r.added, got_r.full));
        end
      end
      stall_cycles <= moved ? 0 : stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // ---------------- main sequence ----------------
  initial begin
    int start_count;
    bit paused;
    logic [63:0] v;
    logic [15:0] ph_uuid [NUM_PHASES];
    logic [15:0] ph_company [NUM_PHASES];
    logic [63:0] ph_prefix [NUM_PHASES];
    logic [3:0]  ph_plen [NUM_PHASES];

    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    in_ch.valid           = 1'b0;
    in_ch.cmd             = 1'b0;
    in_ch.data_byte       = '0;
    in_ch.last_byte       = 1'b0;
    in_ch.device_address  = '0;
    in_ch.signal_strength = '0;
    items_sent   = 0;
    no_idle      = 0;

    want_uuid    = SERVICE_UUID_RST;
    want_company = COMPANY_ID_RST;
    want_prefix  = '0;
    want_plen    = '0;
    parser_restart();
    foreach (dev_used[i]) begin
      dev_used[i] = 0;
      dev_addr[i] = '0;
      dev_rssi[i] = '0;
    end
    foreach (addr_pool[i]) addr_pool[i] = rand48();
    addr_pool[0] = '0;
    addr_pool[1] = ADDR_MAX;

    // settings per phase: all-low, all-high, then mixed, oversized length last-but-one
    ph_uuid[0] = 16'h0000; ph_company[0] = 16'h0000; ph_prefix[0] = '0;  ph_plen[0] = 4'd0;
    ph_uuid[1] = 16'hFFFF; ph_company[1] = 16'hFFFF; ph_prefix[1] = '1;  ph_plen[1] = 4'd8;
    for (int p = 2; p < NUM_PHASES; p++) begin
      ph_uuid[p]    = 16'($urandom);
      ph_company[p] = 16'($urandom);
      for (int k = 0; k < 8; k++) ph_prefix[p][8*k +: 8] = 8'($urandom_range(33, 126));
    end
    ph_plen[2] = 4'd4;
    ph_plen[3] = 4'd15;
    ph_plen[4] = 4'd1;
    ph_uuid[4] = SERVICE_UUID_RST;

    // directed part, reset register values
    add_row(row_t(8'h00, ADDR_MAX, 8'h80, 1'b0, 4'd0, 1'b0));  // zero length
    add_row(row(1'b0, 8'h03, 1'b0, '0, 8'h00));
    add_row(row(1'b0, AD_TYPE_UUID16, 1'b0, '0, 8'h00));
    add_row(row(1'b0, 8'hD0, 1'b0, '0, 8'h00));
    add_row(row_t(8'hFD, ADDR_A, 8'h7F, 1'b1, 4'd0, 1'b1));
    add_row(row(1'b0, 8'h03, 1'b0, ADDR_MAX, 8'hFF));
    add_row(row(1'b0, AD_TYPE_MANUF, 1'b0, ADDR_MAX, 8'hFF));
    add_row(row(1'b0, 8'hFF, 1'b0, ADDR_MAX, 8'hFF));
    add_row(row_t(8'hFF, '0, 8'h00, 1'b1, 4'd1, 1'b1));
    add_row(row(1'b0, 8'h02, 1'b0, '0, 8'h00));
    add_row(row(1'b0, AD_TYPE_NAME, 1'b0, '0, 8'h00));
    add_row(row_t(8'h41, ADDR_A, 8'hFF, 1'b1, 4'd0, 1'b0));  // refresh
    add_row(row(1'b1, 8'hFF, 1'b1, ADDR_MAX, 8'h7F));        // clear table
    add_row(row(1'b0, 8'h03, 1'b0, '0, 8'h00));
    add_row(row(1'b0, AD_TYPE_NAME, 1'b0, '0, 8'h00));
    add_row(row(1'b0, 8'h00, 1'b0, '0, 8'h00));              // empty name
    add_row(row_t(8'h41, ADDR_B, 8'h01, 1'b0, 4'd0, 1'b0));
    add_row(row(1'b0, 8'h05, 1'b0, '0, 8'h00));
    add_row(row(1'b0, AD_TYPE_UUID16, 1'b0, '0, 8'h00));
    add_row(row_t(8'hD0, ADDR_B, 8'h80, 1'b0, 4'd0, 1'b0));  // half UUID
    add_row(row(1'b0, 8'h02, 1'b0, '0, 8'h00));
    add_row(row(1'b0, AD_TYPE_NAME, 1'b0, '0, 8'h00));
    add_row(row_t(8'h7A, '0, 8'h80, 1'b1, 4'd0, 1'b1));      // after clear
    add_row(row(1'b0, 8'h00, 1'b0, '0, 8'h00));
    add_row(row_t(AD_TYPE_NAME, ADDR_B, 8'h00, 1'b0, 4'd0, 1'b0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_item(directed_rows[i]);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clk);
      v = {$urandom, $urandom}; v[15:0] = ph_uuid[p];
      write_reg(CFG_SERVICE_UUID, v);
      v = {$urandom, $urandom}; v[15:0] = ph_company[p];
      write_reg(CFG_COMPANY_ID, v);
      write_reg(CFG_NAME_PREFIX, ph_prefix[p]);
      v = {$urandom, $urandom}; v[3:0] = ph_plen[p];
      write_reg(CFG_PREFIX_LENGTH, v);
      @(negedge clk);
      cfg_we <= 1'b0;
      no_idle = (p == NUM_PHASES - 1);
      start_count = items_sent;
      paused = 0;
      while (items_sent - start_count < PHASE_ITEMS) begin
        if (!paused && items_sent - start_count >= PHASE_ITEMS / 2) begin
          drain_results();
          paused = 1;
        end
        if ($urandom_range(0, 24) == 0)
          send_item(row(1'b1, 8'($urandom), 1'($urandom), rand48(), 8'($urandom)));
        send_advert();
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
